### rtl/core/ftrc_pkg.sv
// Shared types, codes and widths for the fork token resource controller.
package ftrc_pkg;

	localparam int MAX_NB     = 4;
	localparam int ACTION_W   = 3;
	localparam int NB_W       = 2;
	localparam int CNT_W      = 3;
	localparam int NCOUNT_W   = 3;
	localparam int OWNER_W    = 4;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int KIND_W     = 2;
	localparam int PHASE_W    = 2;

	localparam logic [ACTION_W-1:0] ACT_INIT       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_DONE_EAT   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DONE_THINK = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REQ_IN     = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_FORK_IN    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NCOUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWNER  = 1'b1;

	typedef enum logic [PHASE_W-1:0] {
		PH_EAT   = 2'd0,
		PH_HUNGRY = 2'd1,
		PH_THINK = 2'd2
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		K_FORK   = 2'd0,
		K_REQ    = 2'd1,
		K_EAT    = 2'd2,
		K_STATUS = 2'd3
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic              capture;
		logic              init;
		logic              set_phase;
		phase_t            phase_val;
		logic              start_eat;
		logic              give;
		logic              take;
		logic              set_tok;
		logic              clr_tok;
		logic [NB_W-1:0]   sel;
		logic              emit;
		kind_t             kind;
		logic [NB_W-1:0]   target;
		logic              last;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [NB_W-1:0]     nb;
		phase_t              phase;
		logic [CNT_W-1:0]    count;
		logic [MAX_NB-1:0]   holds;
		logic [MAX_NB-1:0]   dirty;
		logic [MAX_NB-1:0]   token;
		logic [MAX_NB-1:0]   nmask;
	} dp_sts_t;

endpackage

### rtl/core/ftrc_if.sv
// Request and result channel interfaces.
interface ftrc_in_if;
	logic                          valid;
	logic                          ready;
	logic [ftrc_pkg::ACTION_W-1:0] action;
	logic [ftrc_pkg::NB_W-1:0]     neighbor;

	modport source (output valid, output action, output neighbor, input ready);
	modport sink   (input valid, input action, input neighbor, output ready);
endinterface

interface ftrc_out_if;
	logic                         valid;
	logic                         ready;
	logic [ftrc_pkg::KIND_W-1:0]  kind;
	logic [ftrc_pkg::NB_W-1:0]    target;
	logic [ftrc_pkg::CNT_W-1:0]   forks_held;
	logic [ftrc_pkg::PHASE_W-1:0] phase;
	logic                         last;

	modport source (output valid, output kind, output target, output forks_held,
		output phase, output last, input ready);
	modport sink   (input valid, input kind, input target, input forks_held,
		input phase, input last, output ready);
endinterface

### rtl/core/ftrc_dp.sv
// Datapath: per-neighbor fork, dirty and token bits, phase and fork count.
module ftrc_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ftrc_pkg::dp_cmd_t              cmd,
	input  logic [ftrc_pkg::CNT_W-1:0]     n_act,
	input  logic [ftrc_pkg::OWNER_W-1:0]   owner,
	input  logic [ftrc_pkg::ACTION_W-1:0]  in_action,
	input  logic [ftrc_pkg::NB_W-1:0]      in_nb,
	output ftrc_pkg::dp_sts_t              sts,
	output logic [ftrc_pkg::CNT_W-1:0]     count_d,
	output ftrc_pkg::phase_t               phase_d
);
	import ftrc_pkg::*;

	function automatic logic [CNT_W-1:0] popcount(input logic [MAX_NB-1:0] v);
		logic [CNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < MAX_NB; i++) begin
			c = c + CNT_W'(v[i]);
		end
		return c;
	endfunction

	logic [ACTION_W-1:0] act_q;
	logic [NB_W-1:0]     nb_q;
	phase_t              phase_q;
	logic [CNT_W-1:0]    count_q;
	logic [MAX_NB-1:0]   holds_q, dirty_q, tok_q;
	logic [MAX_NB-1:0]   holds_d, dirty_d, tok_d, nmask;
	logic                recount;

	always_comb begin
		for (int i = 0; i < MAX_NB; i++) begin
			nmask[i] = CNT_W'(i) < n_act;
		end
	end

	always_comb begin
		holds_d = holds_q;
		dirty_d = dirty_q;
		tok_d   = tok_q;
		phase_d = phase_q;
		recount = 1'b0;
		if (cmd.init) begin
			holds_d = owner & nmask;
			dirty_d = owner & nmask;
			tok_d   = ~owner & nmask;
			phase_d = PH_EAT;
			recount = 1'b1;
		end
		if (cmd.give) begin
			holds_d[cmd.sel] = 1'b0;
			dirty_d[cmd.sel] = 1'b0;
			recount = 1'b1;
		end
		if (cmd.take) begin
			holds_d[cmd.sel] = 1'b1;
			dirty_d[cmd.sel] = 1'b0;
			recount = 1'b1;
		end
		if (cmd.set_tok) tok_d[cmd.sel] = 1'b1;
		if (cmd.clr_tok) tok_d[cmd.sel] = 1'b0;
		if (cmd.set_phase) phase_d = cmd.phase_val;
		// all forks of the active neighbors go dirty when eating starts
		if (cmd.start_eat) dirty_d = dirty_d | nmask;
	end

	assign count_d = recount ? popcount(holds_d & nmask) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EAT;
			count_q <= '0;
			holds_q <= '0;
			dirty_q <= '0;
			tok_q   <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			holds_q <= holds_d;
			dirty_q <= dirty_d;
			tok_q   <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= in_action;
			nb_q  <= in_nb;
		end
	end

	assign sts.act   = act_q;
	assign sts.nb    = nb_q;
	assign sts.phase = phase_q;
	assign sts.count = count_q;
	assign sts.holds = holds_q;
	assign sts.dirty = dirty_q;
	assign sts.token = tok_q;
	assign sts.nmask = nmask;

endmodule

### rtl/core/ftrc_ctrl.sv
// Controller: event decode and one-neighbor-per-cycle walk, held while stalled.
module ftrc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       stall,
	input  logic [ftrc_pkg::CNT_W-1:0] n_act,
	input  ftrc_pkg::dp_sts_t          sts,
	output ftrc_pkg::dp_cmd_t          cmd
);
	import ftrc_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_WALK = 5'b00100,
		ST_REQ2 = 5'b01000,
		ST_STAT = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [NB_W-1:0]  wi;
	logic             nb_ok;
	logic             all_after_take;
	logic [MAX_NB-1:0] nb_hot;

	assign in_ready = (state_q == ST_IDLE);
	assign wi       = idx_q[NB_W-1:0];
	assign nb_ok    = CNT_W'(sts.nb) < n_act;

	always_comb begin
		nb_hot = '0;
		nb_hot[sts.nb] = 1'b1;
	end
	assign all_after_take = ((sts.holds | nb_hot) & sts.nmask) == sts.nmask;

	always_comb begin
		cmd       = '0;
		cmd.phase_val = PH_EAT;
		cmd.kind  = K_STATUS;
		state_d   = state_q;
		idx_d     = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!stall) begin
					state_d = ST_STAT;
					cmd.sel = sts.nb;
					cmd.target = sts.nb;
					unique case (sts.act)
						ACT_INIT: cmd.init = 1'b1;
						ACT_DONE_EAT: begin
							if (sts.phase == PH_EAT) begin
								cmd.set_phase = 1'b1;
								cmd.phase_val = PH_THINK;
								idx_d = '0;
								state_d = ST_WALK;
							end
						end
						ACT_DONE_THINK: begin
							if (sts.phase == PH_THINK) begin
								cmd.set_phase = 1'b1;
								if (sts.count == n_act) begin
									cmd.phase_val = PH_EAT;
									cmd.start_eat = 1'b1;
									cmd.emit = 1'b1;
									cmd.kind = K_EAT;
									cmd.target = '0;
								end else begin
									cmd.phase_val = PH_HUNGRY;
									idx_d = '0;
									state_d = ST_WALK;
								end
							end
						end
						ACT_REQ_IN: begin
							if (nb_ok) begin
								cmd.set_tok = 1'b1;
								if (sts.phase != PH_EAT && sts.dirty[sts.nb]
										&& sts.holds[sts.nb]) begin
									cmd.give = 1'b1;
									cmd.emit = 1'b1;
									cmd.kind = K_FORK;
									if (sts.phase == PH_HUNGRY) state_d = ST_REQ2;
								end
							end
						end
						ACT_FORK_IN: begin
							if (nb_ok) begin
								cmd.take = 1'b1;
								if (sts.phase == PH_HUNGRY && all_after_take) begin
									cmd.start_eat = 1'b1;
									cmd.set_phase = 1'b1;
									cmd.phase_val = PH_EAT;
									cmd.emit = 1'b1;
									cmd.kind = K_EAT;
									cmd.target = '0;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				if (!stall) begin
					if (idx_q >= n_act) begin
						state_d = ST_STAT;
					end else begin
						cmd.sel = wi;
						cmd.target = wi;
						if (sts.act == ACT_DONE_EAT) begin
							if (sts.token[wi] && sts.dirty[wi] && sts.holds[wi]) begin
								cmd.give = 1'b1;
								cmd.emit = 1'b1;
								cmd.kind = K_FORK;
							end
						end else if (sts.token[wi] && !sts.holds[wi]) begin
							cmd.clr_tok = 1'b1;
							cmd.emit = 1'b1;
							cmd.kind = K_REQ;
						end
						idx_d = idx_q + CNT_W'(1);
					end
				end
			end
			ST_REQ2: begin
				if (!stall) begin
					cmd.sel = sts.nb;
					cmd.target = sts.nb;
					cmd.clr_tok = 1'b1;
					cmd.emit = 1'b1;
					cmd.kind = K_REQ;
					state_d = ST_STAT;
				end
			end
			ST_STAT: begin
				if (!stall) begin
					cmd.emit = 1'b1;
					cmd.kind = K_STATUS;
					cmd.last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

### rtl/core/fork_token_resource_controller.sv
// Top level: one node of the fork/token (dining philosophers) protocol.
// Each request on req is one event (init, done eating, done thinking,
// request arrived, fork arrived); it produces one to five results on rsp:
// send-fork, send-request or start-eating messages, always closed by a status
// result with last set. An event runs through accept, execute and status,
// with a walk over the active neighbors (at most 4) added for done eating
// while eating and for done thinking while thinking that does not find every
// fork already in hand, and a second request step added for a request
// arriving while hungry that gives a fork away. The controller walks the
// neighbors one per cycle unless stalled; the single output register holds
// the controller whenever a result there is not taken. A new request is
// accepted once the status result of the previous one sits in the output
// register. Configuration: cfg_idx 0 is the neighbor count (values above
// 4 act as 4), cfg_idx 1 the initial ownership mask; both are used as soon
// as written, so they take effect at the next request only when written
// while idle, and the ownership mask only matters to init.
module fork_token_resource_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ftrc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [ftrc_pkg::CFG_DATA_W-1:0]   cfg_data,
	ftrc_in_if.sink                           req,
	ftrc_out_if.source                        rsp
);
	import ftrc_pkg::*;

	logic [NCOUNT_W-1:0] ncount_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [CNT_W-1:0]    n_act;
	dp_cmd_t             cmd;
	dp_sts_t             sts;
	logic [CNT_W-1:0]    count_d;
	phase_t              phase_d;
	logic                stall;

	// result register
	logic                rsp_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [NB_W-1:0]     target_q;
	logic [CNT_W-1:0]    forks_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= NCOUNT_W'(2);
			owner_q  <= OWNER_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_NCOUNT: ncount_q <= cfg_data[NCOUNT_W-1:0];
				CFG_OWNER:  owner_q  <= cfg_data[OWNER_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp neighbor count to the number of fork slots
	assign n_act = (CNT_W'(ncount_q) > CNT_W'(MAX_NB)) ? CNT_W'(MAX_NB)
		: CNT_W'(ncount_q);

	// controller holds while the result register is full and not drained
	assign stall = rsp_valid_q && !rsp.ready;

	ftrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.stall    (stall),
		.n_act    (n_act),
		.sts      (sts),
		.cmd      (cmd)
	);

	ftrc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.n_act     (n_act),
		.owner     (owner_q),
		.in_action (req.action),
		.in_nb     (req.neighbor),
		.sts       (sts),
		.count_d   (count_d),
		.phase_d   (phase_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// fork count and phase are reported as they stand after this result
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= cmd.kind;
			target_q <= cmd.target;
			forks_q  <= count_d;
			phase_q  <= phase_d;
			last_q   <= cmd.last;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.kind       = kind_q;
	assign rsp.target     = target_q;
	assign rsp.forks_held = forks_q;
	assign rsp.phase      = phase_q;
	assign rsp.last       = last_q;

`ifndef NO_ASSERTIONS
	// status and last mark the same result
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.kind == K_STATUS) == rsp.last))
		else $error("last flag does not match status kind");

	// an accepted request takes the controller out of idle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous one in flight");

	// start eating only with every active fork in hand
	a_eat_all_forks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.kind == K_EAT) |-> (rsp.phase == PH_EAT
			&& rsp.forks_held == n_act))
		else $error("start eating without all forks");
`endif

endmodule
